>>> design/lane_sorted_multi_fifo_macros.svh
// Assertion macros shared by the lane FIFO checker.
`ifndef LANE_SORTED_MULTI_FIFO_MACROS_SVH
`define LANE_SORTED_MULTI_FIFO_MACROS_SVH

// Same-cycle implication, disabled while rst_n is low.
`define LSMF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while rst_n is low.
`define LSMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/lsmf_pkg.sv
// Package: command and lane codes, field widths and the lane control response.
`timescale 1ns / 1ps

package lsmf_pkg;

    localparam int LANE_COUNT   = 3;
    localparam int CMD_W        = 2;
    localparam int SEL_W        = 2;
    localparam int MOVE_W       = 2;
    localparam int RECORD_W     = 32;
    localparam int LANE_FILL_W  = 5;
    localparam int TOTAL_FILL_W = 6;

    localparam int S_TDATA_W = 40;  // move_code, record_in, zero pad
    localparam int S_TUSER_W = 4;   // cmd, lane_sel
    localparam int M_TDATA_W = 48;  // record_out, move_out, lane_fill, total_fill, pad
    localparam int M_TUSER_W = 1;   // ok

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ   = 2'd0,
        CMD_DEQ   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_QUERY = 2'd3
    } lsmf_cmd_t;

    localparam logic [SEL_W-1:0] SEL_LEFT      = 2'd0;
    localparam logic [SEL_W-1:0] SEL_STRAIGHT  = 2'd1;
    localparam logic [SEL_W-1:0] SEL_RIGHT     = 2'd2;
    localparam logic [SEL_W-1:0] LANE_NONE     = 2'd3;

    localparam logic [MOVE_W-1:0] MV_INVALID  = 2'd0;
    localparam logic [MOVE_W-1:0] MV_LEFT     = 2'd1;
    localparam logic [MOVE_W-1:0] MV_STRAIGHT = 2'd2;
    localparam logic [MOVE_W-1:0] MV_RIGHT    = 2'd3;

    // Per-beat result info handed from lane control to the output pipe.
    typedef struct packed {
        logic                    ok;
        logic                    rd;     // head entry is returned
        logic [SEL_W-1:0]        lane;
        logic [LANE_FILL_W-1:0]  lane_fill;
        logic [TOTAL_FILL_W-1:0] total_fill;
    } lsmf_rsp_t;

    // Invalid movement falls back to the left lane.
    function automatic logic [SEL_W-1:0] lane_of_move(input logic [MOVE_W-1:0] mv);
        logic [SEL_W-1:0] lane;
        case (mv)
            MV_STRAIGHT: lane = SEL_STRAIGHT;
            MV_RIGHT:    lane = SEL_RIGHT;
            MV_LEFT:     lane = SEL_LEFT;
            default:     lane = SEL_LEFT;
        endcase
        return lane;
    endfunction

endpackage

>>> design/lane_sorted_multi_fifo.sv
// Top level: three lane FIFOs sorted by movement code, stream in and out.
// An s_ beat goes to m_ via the RAM read stage and output register; pointers and counts
// update in the accept cycle. Throughput: one beat per cycle while s_tready is high.
// s_tready drops only when the RAM read stage and the output register both hold beats
// and m_tready is low.
// Reset (aresetn low, synchronous): pointers, counts and valid flags clear; RAM is not
// cleared, since a lane's head is only returned while its fill count is nonzero.
`timescale 1ns / 1ps

module lane_sorted_multi_fifo
    import lsmf_pkg::*;
#(
    parameter int LANE_DEPTH  = 16,
    parameter int RECORD_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: move_code[1:0], record_in[33:2], zero [39:34]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: cmd[1:0], lane_sel[3:2]
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // m_tdata: record_out[31:0], move_out[33:32], lane_fill[38:34],
    //          total_fill[44:39], zero [47:45]
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: ok[0]
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready
);

    localparam int PTR_W      = $clog2(LANE_DEPTH);
    localparam int STORE_BITS = (RECORD_BITS < RECORD_W) ? RECORD_BITS : RECORD_W;
    localparam int ENTRY_W    = STORE_BITS + MOVE_W;
    localparam int PAD_W      = M_TDATA_W - RECORD_W - MOVE_W - LANE_FILL_W - TOTAL_FILL_W;

    // Input beat fields
    logic [CMD_W-1:0]    cmd;
    logic [SEL_W-1:0]    lane_sel;
    logic [MOVE_W-1:0]   move_code;
    logic [RECORD_W-1:0] record_in;

    assign cmd       = s_tuser[CMD_W-1:0];
    assign lane_sel  = s_tuser[CMD_W +: SEL_W];
    assign move_code = s_tdata[MOVE_W-1:0];
    assign record_in = s_tdata[MOVE_W +: RECORD_W];

    logic accept;
    logic out_adv;

    // Stage 1 state: response info waits beside the RAM read data.
    logic      st1_valid_reg, st1_valid_next;
    lsmf_rsp_t st1_rsp_reg;

    assign out_adv  = !m_tvalid || m_tready;
    assign s_tready = !st1_valid_reg || out_adv;
    assign accept   = s_tvalid && s_tready;

    // Lane pointers and counts; all state moves at the accept edge.
    logic [LANE_COUNT-1:0]            wr_en;
    logic [LANE_COUNT-1:0][PTR_W-1:0] head_ptr;
    logic [LANE_COUNT-1:0][PTR_W-1:0] tail_ptr;
    lsmf_rsp_t                        rsp;

    lsmf_lane_ctrl #(
        .LANE_DEPTH (LANE_DEPTH)
    ) u_lane_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .cmd       (cmd),
        .lane_sel  (lane_sel),
        .move_code (move_code),
        .wr_en     (wr_en),
        .head_ptr  (head_ptr),
        .tail_ptr  (tail_ptr),
        .rsp       (rsp)
    );

    // One RAM per lane; each reads its own head on every accepted beat and
    // holds the word until the next one, so a stall keeps the data.
    logic [ENTRY_W-1:0] wr_word;
    logic [ENTRY_W-1:0] rd_word [LANE_COUNT];

    assign wr_word = {move_code, record_in[STORE_BITS-1:0]};

    for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
        lsmf_ram #(
            .WIDTH (ENTRY_W),
            .DEPTH (LANE_DEPTH)
        ) u_ram (
            .aclk    (aclk),
            .wr_en   (wr_en[g]),
            .wr_addr (tail_ptr[g]),
            .wr_data (wr_word),
            .rd_en   (accept),
            .rd_addr (head_ptr[g]),
            .rd_data (rd_word[g])
        );
    end

    // Stage 1: response info waits beside the RAM read data.
    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (accept) begin
            st1_valid_next = 1'b1;
        end else if (out_adv) begin
            st1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_rsp_reg <= rsp;
        end
    end

    // Head entry of the selected lane; zero unless a dequeue or peek hit.
    logic [ENTRY_W-1:0]  sel_word;
    logic [RECORD_W-1:0] record_out;
    logic [MOVE_W-1:0]   move_out;

    always_comb begin
        sel_word = '0;
        for (int i = 0; i < LANE_COUNT; i++) begin
            if (st1_rsp_reg.lane == SEL_W'(i)) begin
                sel_word = rd_word[i];
            end
        end
        record_out = '0;
        move_out   = '0;
        if (st1_rsp_reg.rd) begin
            record_out = RECORD_W'(sel_word[STORE_BITS-1:0]);
            move_out   = sel_word[STORE_BITS +: MOVE_W];
        end
    end

    // Stage 2: output register.
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_adv) begin
            m_valid_next = st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && st1_valid_reg) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, st1_rsp_reg.total_fill, st1_rsp_reg.lane_fill,
                            move_out, record_out};
            m_tuser_reg <= M_TUSER_W'(st1_rsp_reg.ok);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> design/lsmf_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module lsmf_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/lsmf_lane_ctrl.sv
// Lane control: head/tail pointers, fill counts and per-beat decode.
`timescale 1ns / 1ps

module lsmf_lane_ctrl
    import lsmf_pkg::*;
#(
    parameter int LANE_DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       accept,
    input  logic [CMD_W-1:0]                           cmd,
    input  logic [SEL_W-1:0]                           lane_sel,
    input  logic [MOVE_W-1:0]                          move_code,
    output logic [LANE_COUNT-1:0]                      wr_en,
    output logic [LANE_COUNT-1:0][$clog2(LANE_DEPTH)-1:0] head_ptr,
    output logic [LANE_COUNT-1:0][$clog2(LANE_DEPTH)-1:0] tail_ptr,
    output lsmf_rsp_t                                  rsp
);

    localparam int PTR_W = $clog2(LANE_DEPTH);
    localparam int CNT_W = $clog2(LANE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 2;

    logic [LANE_COUNT-1:0][PTR_W-1:0] head_reg, head_next;
    logic [LANE_COUNT-1:0][PTR_W-1:0] tail_reg, tail_next;
    logic [LANE_COUNT-1:0][CNT_W-1:0] cnt_reg,  cnt_next;

    logic [SEL_W-1:0] lane;
    logic             lane_ok;
    logic [CNT_W-1:0] sel_cnt;
    logic [CNT_W-1:0] sel_fill;
    logic [SUM_W-1:0] total;
    logic             ok;
    logic             rd;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(LANE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        lane    = (cmd == CMD_ENQ) ? lane_of_move(move_code) : lane_sel;
        lane_ok = (cmd == CMD_ENQ) || (lane_sel != LANE_NONE);

        sel_cnt = '0;
        for (int i = 0; i < LANE_COUNT; i++) begin
            if (lane == SEL_W'(i)) begin
                sel_cnt = cnt_reg[i];
            end
        end

        ok = 1'b0;
        rd = 1'b0;
        case (lsmf_cmd_t'(cmd))
            CMD_ENQ:   ok = (sel_cnt != CNT_W'(LANE_DEPTH));
            CMD_DEQ,
            CMD_PEEK: begin
                ok = lane_ok && (sel_cnt != '0);
                rd = ok;
            end
            CMD_QUERY: ok = lane_ok;
            default:   ok = 1'b0;
        endcase

        do_push = accept && (cmd == CMD_ENQ) && ok;
        do_pop  = accept && (cmd == CMD_DEQ) && ok;

        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        wr_en     = '0;
        for (int i = 0; i < LANE_COUNT; i++) begin
            if (lane == SEL_W'(i)) begin
                if (do_push) begin
                    wr_en[i]     = 1'b1;
                    tail_next[i] = advance(tail_reg[i]);
                    cnt_next[i]  = cnt_reg[i] + 1'b1;
                end
                if (do_pop) begin
                    head_next[i] = advance(head_reg[i]);
                    cnt_next[i]  = cnt_reg[i] - 1'b1;
                end
            end
        end

        sel_fill = '0;
        total    = '0;
        for (int i = 0; i < LANE_COUNT; i++) begin
            if (lane_ok && (lane == SEL_W'(i))) begin
                sel_fill = cnt_next[i];
            end
            total = total + SUM_W'(cnt_next[i]);
        end

        rsp.ok         = ok;
        rsp.rd         = rd;
        rsp.lane       = lane;
        rsp.lane_fill  = LANE_FILL_W'(sel_fill);
        rsp.total_fill = TOTAL_FILL_W'(total);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Reads at the accept edge use the head before a pop moves it.
    assign head_ptr = head_reg;
    assign tail_ptr = tail_reg;

endmodule

>>> design/lsmf_checker.sv
// Port-level checker for the lane FIFO top level, bound to it.
`timescale 1ns / 1ps
`include "lane_sorted_multi_fifo_macros.svh"

module lsmf_checker
    import lsmf_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // Output register empties on reset.
    `LSMF_ASSERT_NEXT(a_reset_clears, aclk, 1'b1, !aresetn, !m_tvalid, "m_tvalid after reset")

    // A failed beat carries no record or movement.
    `LSMF_ASSERT_NOW(a_fail_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[33:0] == '0, "record on failed beat")

    // Stalled beat stays up with the same content.
    `LSMF_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped")
    `LSMF_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled beat changed")

endmodule

bind lane_sorted_multi_fifo lsmf_checker u_lsmf_checker (.*);

>>> tb/sv/tb_lane_sorted_multi_fifo.sv
// Testbench for lane_sorted_multi_fifo: directed and random beats checked against a scoreboard.
`timescale 1ns / 1ps

module tb_lane_sorted_multi_fifo;
    import lsmf_pkg::*;

    localparam int DEPTH      = 16;
    localparam int STALL_MAX  = 4000;  // cycles without any handshake before giving up
    localparam int PHASE_ITEMS = 345;  // random beats per idling phase, three phases

    // Traffic shape for one random burst.
    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

    // One expected result beat.
    typedef struct {
        logic                    ok;
        logic [RECORD_W-1:0]     rec;
        logic [MOVE_W-1:0]       mv;
        logic [LANE_FILL_W-1:0]  lane_fill;
        logic [TOTAL_FILL_W-1:0] total_fill;
    } lane_result_t;

    // Shadow copy of the three lane queues plus the pending results.
    class fifo_scoreboard;
        logic [RECORD_W-1:0] rec_mem [LANE_COUNT][DEPTH];
        logic [MOVE_W-1:0]   mv_mem  [LANE_COUNT][DEPTH];
        int unsigned         head    [LANE_COUNT] = '{0, 0, 0};
        int unsigned         tail    [LANE_COUNT] = '{0, 0, 0};
        int unsigned         fill    [LANE_COUNT] = '{0, 0, 0};
        lane_result_t        expected_q[$];
        int                  errors = 0;

        // Apply one accepted command to the shadow lanes and queue its result.
        function void note_input(lsmf_cmd_t cmd, logic [SEL_W-1:0] sel,
                                 logic [MOVE_W-1:0] mv, logic [RECORD_W-1:0] rec);
            lane_result_t r;
            int lane;
            int unsigned sum;
            r = '{ok: 1'b0, rec: '0, mv: '0, lane_fill: '0, total_fill: '0};
            if (cmd == CMD_ENQ) begin
                // straight and right have their own lanes; left and invalid share lane 0
                if (mv == MV_STRAIGHT)
                    lane = int'(SEL_STRAIGHT);
                else if (mv == MV_RIGHT)
                    lane = int'(SEL_RIGHT);
                else
                    lane = int'(SEL_LEFT);
                if (fill[lane] < DEPTH) begin
                    rec_mem[lane][tail[lane]] = rec;
                    mv_mem[lane][tail[lane]]  = mv;
                    tail[lane] = (tail[lane] + 1) % DEPTH;
                    fill[lane]++;
                    r.ok = 1'b1;
                end
                r.lane_fill = LANE_FILL_W'(fill[lane]);
            end else if (sel != LANE_NONE) begin
                lane = int'(sel);
                if (cmd == CMD_QUERY) begin
                    r.ok = 1'b1;
                end else if (fill[lane] != 0) begin
                    r.rec = rec_mem[lane][head[lane]];
                    r.mv  = mv_mem[lane][head[lane]];
                    r.ok  = 1'b1;
                    if (cmd == CMD_DEQ) begin
                        head[lane] = (head[lane] + 1) % DEPTH;
                        fill[lane]--;
                    end
                end
                r.lane_fill = LANE_FILL_W'(fill[lane]);
            end
            sum = fill[0] + fill[1] + fill[2];
            r.total_fill = TOTAL_FILL_W'(sum);
            expected_q.push_back(r);
        endfunction

        // Compare one result beat with the oldest expectation.
        function void check_result(logic [M_TDATA_W-1:0] d, logic [M_TUSER_W-1:0] u);
            lane_result_t e;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected: tdata %h tuser %h", d, u);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (u[0] !== e.ok) begin
                $error("ok mismatch: expected %0d, actual %0d", e.ok, u[0]);
                errors++;
            end
            if (d[31:0] !== e.rec) begin
                $error("record_out mismatch: expected %h, actual %h", e.rec, d[31:0]);
                errors++;
            end
            if (d[33:32] !== e.mv) begin
                $error("move_out mismatch: expected %0d, actual %0d", e.mv, d[33:32]);
                errors++;
            end
            if (d[38:34] !== e.lane_fill) begin
                $error("lane_fill mismatch: expected %0d, actual %0d",
                       e.lane_fill, d[38:34]);
                errors++;
            end
            if (d[44:39] !== e.total_fill) begin
                $error("total_fill mismatch: expected %0d, actual %0d",
                       e.total_fill, d[44:39]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // move_code[1:0], record_in[33:2], zero [39:34]
    logic [S_TUSER_W-1:0] s_tuser  = '0;   // cmd[1:0], lane_sel[3:2]
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;         // record_out, move_out, lane_fill, total_fill, pad
    logic [M_TUSER_W-1:0] m_tuser;         // ok[0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    int s_idle_pct = 6;    // chance per cycle that the sender holds back
    int m_idle_pct = 87;   // chance per cycle that the receiver stalls
    int quiet_cycles = 0;

    fifo_scoreboard sb = new;

    lane_sorted_multi_fifo #(
        .LANE_DEPTH  (DEPTH),
        .RECORD_BITS (RECORD_W)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Receiver: ready is redrawn every falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    // Monitor at the rising edge: note accepted commands, check result beats,
    // and watch for a hang.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_input(lsmf_cmd_t'(s_tuser[1:0]), s_tuser[3:2],
                              s_tdata[1:0], s_tdata[33:2]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_MAX) begin
                $display("watchdog: %0d cycles without a beat, %0d results pending",
                         quiet_cycles, sb.pending());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Present one beat; called at a falling edge, returns at the falling edge
    // after the beat was taken, with tvalid still high.
    task automatic send_beat(input lsmf_cmd_t cmd, input logic [SEL_W-1:0] sel,
                             input logic [MOVE_W-1:0] mv, input logic [RECORD_W-1:0] rec);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, rec, mv};
        s_tuser  <= {sel, cmd};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic drain_pause();
        s_tvalid <= 1'b0;
        do
            @(negedge aclk);
        while (sb.pending() != 0);
    endtask

    // One random beat, shaped by the burst mix and biased toward a focus lane
    // so that lanes actually hit full and empty.
    task automatic send_random(input mix_t mix, input int focus);
        lsmf_cmd_t         cmd;
        logic [SEL_W-1:0]  sel;
        logic [MOVE_W-1:0] mv;
        logic [RECORD_W-1:0] rec;
        int roll;
        roll = $urandom_range(0, 99);
        sel  = SEL_W'($urandom_range(0, 3));
        mv   = MOVE_W'($urandom_range(0, 3));
        rec  = $urandom;
        case (mix)
            MIX_FILL: begin
                if (roll < 85)      cmd = CMD_ENQ;
                else if (roll < 92) cmd = CMD_PEEK;
                else if (roll < 96) cmd = CMD_QUERY;
                else                cmd = CMD_DEQ;
            end
            MIX_DRAIN: begin
                if (roll < 70)      cmd = CMD_DEQ;
                else if (roll < 85) cmd = CMD_PEEK;
                else if (roll < 93) cmd = CMD_QUERY;
                else                cmd = CMD_ENQ;
            end
            default: begin
                if (roll < 40)      cmd = CMD_ENQ;
                else if (roll < 75) cmd = CMD_DEQ;
                else if (roll < 90) cmd = CMD_PEEK;
                else                cmd = CMD_QUERY;
            end
        endcase
        // three in four beats aim at the focus lane; the rest keep random
        // fields, which also covers the invalid lane
        if ($urandom_range(0, 3) != 0) begin
            case (focus)
                1: begin
                    sel = SEL_STRAIGHT;
                    mv  = MV_STRAIGHT;
                end
                2: begin
                    sel = SEL_RIGHT;
                    mv  = MV_RIGHT;
                end
                default: begin
                    sel = SEL_LEFT;
                    mv  = $urandom_range(0, 1) ? MV_LEFT : MV_INVALID;
                end
            endcase
        end
        roll = $urandom_range(0, 99);
        if (roll < 5)
            rec = '0;
        else if (roll < 10)
            rec = '1;
        send_beat(cmd, sel, mv, rec);
    endtask

    initial begin
        int sent;
        int burst;
        int focus;
        mix_t mix;

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: queries and reads on empty lanes, the invalid lane,
        // one enqueue per movement code with extreme records, then reads back.
        send_beat(CMD_QUERY, SEL_LEFT,     MV_INVALID, '0);
        send_beat(CMD_QUERY, SEL_STRAIGHT, MV_INVALID, '0);
        send_beat(CMD_QUERY, SEL_RIGHT,    MV_INVALID, '0);
        send_beat(CMD_QUERY, LANE_NONE,    MV_RIGHT,   '1);
        send_beat(CMD_DEQ,   SEL_STRAIGHT, MV_RIGHT,   '1);
        send_beat(CMD_PEEK,  SEL_RIGHT,    MV_LEFT,    '0);
        send_beat(CMD_DEQ,   LANE_NONE,    MV_LEFT,    '0);
        send_beat(CMD_PEEK,  LANE_NONE,    MV_LEFT,    '0);
        send_beat(CMD_ENQ,   LANE_NONE,    MV_INVALID,  32'hFFFF_FFFF);
        send_beat(CMD_ENQ,   SEL_RIGHT,    MV_LEFT,     32'h0000_0000);
        send_beat(CMD_ENQ,   SEL_LEFT,     MV_STRAIGHT, 32'hAAAA_AAAA);
        send_beat(CMD_ENQ,   SEL_STRAIGHT, MV_RIGHT,    32'h5555_5555);
        // invalid-lane dequeue with lanes populated: must not disturb them
        send_beat(CMD_DEQ,   LANE_NONE,    MV_INVALID, '0);
        send_beat(CMD_PEEK,  SEL_LEFT,     MV_INVALID, '0);
        send_beat(CMD_DEQ,   SEL_LEFT,     MV_INVALID, '0);
        send_beat(CMD_DEQ,   SEL_LEFT,     MV_INVALID, '0);
        send_beat(CMD_DEQ,   SEL_LEFT,     MV_INVALID, '0);
        send_beat(CMD_DEQ,   SEL_STRAIGHT, MV_INVALID, '0);
        send_beat(CMD_PEEK,  SEL_RIGHT,    MV_INVALID, '0);
        send_beat(CMD_DEQ,   SEL_RIGHT,    MV_INVALID, '0);
        send_beat(CMD_QUERY, SEL_RIGHT,    MV_INVALID, '0);

        // Random bursts in three idling phases; the sender waits for the
        // pipe to empty between phases.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    s_idle_pct = 6;
                    m_idle_pct = 87;
                end
                1: begin
                    s_idle_pct = 87;
                    m_idle_pct = 6;
                end
                default: begin
                    s_idle_pct = 0;
                    m_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(10, 50);
                if (burst > PHASE_ITEMS - sent)
                    burst = PHASE_ITEMS - sent;
                focus = $urandom_range(0, 2);
                case ($urandom_range(0, 2))
                    0:       mix = MIX_FILL;
                    1:       mix = MIX_DRAIN;
                    default: mix = MIX_BALANCED;
                endcase
                for (int i = 0; i < burst; i++)
                    send_random(mix, focus);
                sent += burst;
            end
            drain_pause();
        end

        // Everything has returned; keep the clock running so that any stray
        // beat would still show.
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/lsmf_pkg.sv
design/lsmf_ram.sv
design/lsmf_lane_ctrl.sv
design/lane_sorted_multi_fifo.sv
design/lsmf_checker.sv
tb/sv/tb_lane_sorted_multi_fifo.sv
